// ===== rtl/touchpad_gesture_engine_defines.svh =====
// ----------------------------------------------------------------------------
// touchpad_gesture_engine_defines.svh
// Assertion macros shared by the gesture engine checkers.
// ----------------------------------------------------------------------------
`ifndef TOUCHPAD_GESTURE_ENGINE_DEFINES_SVH
`define TOUCHPAD_GESTURE_ENGINE_DEFINES_SVH

// Property checked only while out of reset.
`define TGE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that also covers the reset cycles.
`define TGE_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/tge_pkg.sv =====
// ----------------------------------------------------------------------------
// tge_pkg
// Codes, reset values and result type of the touchpad gesture engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package tge_pkg;

  localparam int PTR_DIV_DEF  = 4;
  localparam int MOVE_THR_DEF = 80;

  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 48;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // input op (travels on in_tuser)
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // result kind (travels on out_tuser)
  localparam logic [1:0] KIND_MOVE   = 2'd0;
  localparam logic [1:0] KIND_WHEEL  = 2'd1;
  localparam logic [1:0] KIND_BUTTON = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WMAX   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HMAX   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MARGIN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_STEP   = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TAPTO  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_DTW    = 4'd7;

  // register reset values
  localparam logic [2:0]  MODE_RST   = 3'd0;
  localparam logic [5:0]  THRESH_RST = 6'd8;
  localparam logic [11:0] WMAX_RST   = 12'd2047;
  localparam logic [11:0] HMAX_RST   = 12'd2047;
  localparam logic [10:0] MARGIN_RST = 11'd220;
  localparam logic [15:0] STEP_RST   = 16'd160;
  localparam logic [15:0] TAPTO_RST  = 16'd180;
  localparam logic [15:0] DTW_RST    = 16'd350;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [12:0] move_x;
    logic signed [12:0] move_y;
    logic signed [15:0] wheel_steps;
    logic               button_down;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/touchpad_gesture_engine.sv =====
// ----------------------------------------------------------------------------
// touchpad_gesture_engine
// Turns absolute touch samples and time ticks into pointer, wheel and
// button requests.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one request per sample (in_tuser = 0) or bare time tick
//           (in_tuser = 1). in_tready is high only while the engine is idle.
//   out_* : zero to four result requests per input, out_tlast on the final
//           one. out_tuser carries the kind (move, wheel, button).
//   cfg_* : register writes, always ready; write only while idle.
// Steps per input (accept to first result):
//   capture, gesture evaluation, then the shared 20-bit restoring divider:
//   one division for a wheel update, two for a pointer move (x then y
//   through the same unit), none for touch down/up or ticks. Results then
//   leave on out_*; the next input is taken only after the last result is
//   accepted. An input with no result (also a wheel update with zero
//   steps) frees the engine without using out_*.
// Reset (rst_n low, synchronous): gesture state clears, registers return to
//   their defaults, no result pending, in_tready high next cycle.
// Stall: results wait in a four-entry buffer; out_* holds until taken and no
//   new input is accepted meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module touchpad_gesture_engine #(
  parameter int PTR_DIVISOR    = tge_pkg::PTR_DIV_DEF,
  parameter int MOVE_THRESHOLD = tge_pkg::MOVE_THR_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // in_tdata: pos_x[11:0], pos_y[23:12], pressure[29:24], time_ms[61:30]
  input  wire logic [tge_pkg::IN_DATA_W-1:0]  in_tdata,
  input  wire logic                           in_tuser,  // op
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // out_tdata: move_x[12:0], move_y[25:13], wheel_steps[41:26],
  //            button_down[42]
  output logic [tge_pkg::OUT_DATA_W-1:0]      out_tdata,
  output logic [1:0]                          out_tuser, // kind
  output logic                                out_tlast,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [tge_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tge_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready
);
  import tge_pkg::*;

  localparam int DIV_W   = 20;
  localparam int PDIV_EFF = (PTR_DIVISOR == 0) ? 1 : PTR_DIVISOR;

  typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DIV, ST_OUT} state_t;
  typedef enum logic [1:0] {SEL_X, SEL_Y, SEL_W} div_sel_t;

  state_t   state_r, state_nxt;
  div_sel_t sel_r, sel_nxt;

  // configuration
  logic [2:0]  mode_r, mode_nxt;
  logic [5:0]  thr_r, thr_nxt;
  logic [11:0] wmax_r, wmax_nxt, hmax_r, hmax_nxt;
  logic [10:0] margin_r, margin_nxt;
  logic [15:0] step_r, step_nxt, tapto_r, tapto_nxt, dtw_r, dtw_nxt;

  // gesture state
  logic        touching_r, touching_nxt, moved_r, moved_nxt;
  logic        scroll_r, scroll_nxt, drag_r, drag_nxt, pend_r, pend_nxt;
  logic [14:0] ringpos_r, ringpos_nxt;
  logic signed [19:0] accum_r, accum_nxt;
  logic [11:0] prevx_r, prevx_nxt, prevy_r, prevy_nxt;
  logic [31:0] tstart_r, tstart_nxt, taptime_r, taptime_nxt;

  // captured input
  logic        op_r, op_nxt;
  logic [11:0] x_r, x_nxt, y_r, y_nxt;
  logic [5:0]  z_r, z_nxt;
  logic [31:0] now_r, now_nxt;

  // shared divider
  logic [DIV_W-1:0] quo_r, quo_nxt;
  logic [15:0]      rem_r, rem_nxt, dsr_r, dsr_nxt;
  logic [4:0]       iter_r, iter_nxt;
  logic             neg_r, neg_nxt;
  logic signed [12:0] dy_r, dy_nxt, mx_r, mx_nxt;

  // result buffer
  res_t       res_r [4];
  res_t       res_nxt [4];
  logic [2:0] cnt_r, cnt_nxt;
  logic [1:0] oidx_r, oidx_nxt;

  function automatic res_t mk_btn(logic down);
    res_t e;
    e = '0;
    e.kind = KIND_BUTTON;
    e.button_down = down;
    return e;
  endfunction

  function automatic logic in_edge(logic [11:0] x, logic [11:0] y, logic [11:0] wm,
                                   logic [11:0] hm, logic [10:0] m);
    logic signed [13:0] xs, ys, ms, rl, bl;
    xs = $signed({2'b0, x});
    ys = $signed({2'b0, y});
    ms = $signed({3'b0, m});
    rl = $signed({2'b0, wm}) - ms;
    bl = $signed({2'b0, hm}) - ms;
    return (xs <= ms) || (xs >= rl) || (ys <= ms) || (ys >= bl);
  endfunction

  // position on the ring around the pad: top, right, bottom, left
  function automatic logic [14:0] ring_at(logic [11:0] x, logic [11:0] y, logic [11:0] wm,
                                          logic [11:0] hm, logic [10:0] m);
    logic signed [15:0] xs, ys, ms, xm, ym, r;
    xs = $signed({4'b0, x});
    ys = $signed({4'b0, y});
    ms = $signed({5'b0, m});
    xm = $signed({4'b0, wm});
    ym = $signed({4'b0, hm});
    if (ys <= ms) begin
      r = xs;
    end else if (xs >= xm - ms) begin
      r = xm + ys;
    end else if (ys >= ym - ms) begin
      r = xm + ym + (xm - xs);
    end else begin
      r = xm + xm + ym + (ym - ys);
    end
    return r[14:0];
  endfunction

  logic [16:0] rem_sh;
  logic        div_ge;
  logic [DIV_W-1:0] quo_step;
  logic [15:0] rem_step;

  assign rem_sh   = {rem_r, quo_r[DIV_W-1]};
  assign div_ge   = rem_sh >= {1'b0, dsr_r};
  assign rem_step = div_ge ? 16'(rem_sh - {1'b0, dsr_r}) : rem_sh[15:0];
  assign quo_step = {quo_r[DIV_W-2:0], div_ge};

  assign in_tready  = (state_r == ST_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tuser  = res_r[oidx_r].kind;
  assign out_tlast  = ({1'b0, oidx_r} == 3'(cnt_r - 3'd1));
  assign out_tdata  = {5'b0, res_r[oidx_r].button_down, res_r[oidx_r].wheel_steps,
                       res_r[oidx_r].move_y, res_r[oidx_r].move_x};

  always_comb begin
    logic [2:0]  n;
    logic        pend, drag, go_div;
    logic [31:0] age, held;
    logic signed [12:0] dx, dy, ax, ay;
    logic [14:0] pos;
    logic signed [16:0] half, per, d;
    logic signed [19:0] acc_new, acc_mag;
    logic signed [20:0] steps;
    logic [12:0] qn;

    state_nxt = state_r;  sel_nxt = sel_r;
    mode_nxt = mode_r;  thr_nxt = thr_r;  wmax_nxt = wmax_r;  hmax_nxt = hmax_r;
    margin_nxt = margin_r;  step_nxt = step_r;  tapto_nxt = tapto_r;  dtw_nxt = dtw_r;
    touching_nxt = touching_r;  moved_nxt = moved_r;  scroll_nxt = scroll_r;
    drag_nxt = drag_r;  pend_nxt = pend_r;  ringpos_nxt = ringpos_r;
    accum_nxt = accum_r;  prevx_nxt = prevx_r;  prevy_nxt = prevy_r;
    tstart_nxt = tstart_r;  taptime_nxt = taptime_r;
    op_nxt = op_r;  x_nxt = x_r;  y_nxt = y_r;  z_nxt = z_r;  now_nxt = now_r;
    quo_nxt = quo_r;  rem_nxt = rem_r;  dsr_nxt = dsr_r;  iter_nxt = iter_r;
    neg_nxt = neg_r;  dy_nxt = dy_r;  mx_nxt = mx_r;
    res_nxt = res_r;  cnt_nxt = cnt_r;  oidx_nxt = oidx_r;

    n = cnt_r;  pend = pend_r;  drag = drag_r;  go_div = 1'b0;
    age = now_r - taptime_r;
    held = now_r - tstart_r;
    dx = $signed({1'b0, x_r}) - $signed({1'b0, prevx_r});
    dy = $signed({1'b0, y_r}) - $signed({1'b0, prevy_r});
    ax = dx[12] ? -dx : dx;
    ay = dy[12] ? -dy : dy;
    pos = ring_at(x_r, y_r, wmax_r, hmax_r, margin_r);
    half = $signed({5'b0, wmax_r}) + $signed({5'b0, hmax_r});
    per = half + half;
    d = $signed({2'b0, pos}) - $signed({2'b0, ringpos_r});
    if (d > half) begin
      d = d - per;
    end else if (d < -half) begin
      d = d + per;
    end
    acc_new = accum_r + 20'(d);
    acc_mag = acc_new[19] ? -acc_new : acc_new;
    steps = '0;
    qn = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt  = in_tuser;
          x_nxt   = in_tdata[11:0];
          y_nxt   = in_tdata[23:12];
          z_nxt   = in_tdata[29:24];
          now_nxt = in_tdata[61:30];
          cnt_nxt = '0;
          oidx_nxt = '0;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        // deferred single click
        if (pend && age >= {16'b0, dtw_r}) begin
          if (!drag) begin
            res_nxt[n[1:0]] = mk_btn(1'b1);  n = n + 3'd1;
            res_nxt[n[1:0]] = mk_btn(1'b0);  n = n + 3'd1;
          end
          pend = 1'b0;
        end
        if (op_r == OP_SAMPLE) begin
          if (z_r < thr_r) begin
            if (touching_r && mode_r[0] && !moved_r && held <= {16'b0, tapto_r}) begin
              if (mode_r[1] && pend && age <= {16'b0, dtw_r}) begin
                res_nxt[n[1:0]] = mk_btn(!drag);  n = n + 3'd1;
                drag = !drag;
                pend = 1'b0;
              end else if (mode_r[1]) begin
                taptime_nxt = now_r;
                pend = 1'b1;
              end else begin
                if (!drag) begin
                  res_nxt[n[1:0]] = mk_btn(1'b1);  n = n + 3'd1;
                  res_nxt[n[1:0]] = mk_btn(1'b0);  n = n + 3'd1;
                end
                pend = 1'b0;
              end
            end
            touching_nxt = 1'b0;
            scroll_nxt = 1'b0;
            accum_nxt = '0;
          end else if (!touching_r) begin
            touching_nxt = 1'b1;
            moved_nxt = 1'b0;
            scroll_nxt = in_edge(x_r, y_r, wmax_r, hmax_r, margin_r);
            ringpos_nxt = pos;
            prevx_nxt = x_r;  prevy_nxt = y_r;
            tstart_nxt = now_r;
          end else begin
            if (ax > 13'(MOVE_THRESHOLD) || ay > 13'(MOVE_THRESHOLD)) moved_nxt = 1'b1;
            if (!scroll_r && in_edge(x_r, y_r, wmax_r, hmax_r, margin_r)) begin
              scroll_nxt = 1'b1;
              ringpos_nxt = pos;
            end else if (scroll_r) begin
              ringpos_nxt = pos;
              accum_nxt = acc_new;
              quo_nxt = acc_mag;
              neg_nxt = acc_new[19];
              dsr_nxt = (step_r == 16'd0) ? 16'd1 : step_r;
              sel_nxt = SEL_W;
              go_div = 1'b1;
            end else begin
              quo_nxt = DIV_W'(ax);
              neg_nxt = dx[12];
              dy_nxt = dy;
              dsr_nxt = 16'(PDIV_EFF);
              sel_nxt = SEL_X;
              go_div = 1'b1;
            end
            prevx_nxt = x_r;  prevy_nxt = y_r;
          end
        end
        pend_nxt = pend;
        drag_nxt = drag;
        cnt_nxt = n;
        rem_nxt = '0;
        iter_nxt = '0;
        if (go_div) state_nxt = ST_DIV;
        else if (n != 3'd0) state_nxt = ST_OUT;
        else state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        iter_nxt = iter_r + 5'd1;
        if (iter_r == 5'(DIV_W - 1)) begin
          qn = neg_r ? 13'(13'd0 - quo_step[12:0]) : quo_step[12:0];
          iter_nxt = '0;
          rem_nxt = '0;
          case (sel_r)
            SEL_X: begin
              mx_nxt = $signed(qn);
              quo_nxt = DIV_W'(dy_r[12] ? -dy_r : dy_r);
              neg_nxt = dy_r[12];
              sel_nxt = SEL_Y;
            end
            SEL_Y: begin
              res_nxt[cnt_r[1:0]] = '{KIND_MOVE, mx_r, $signed(qn), 16'sd0, 1'b0};
              cnt_nxt = cnt_r + 3'd1;
              state_nxt = ST_OUT;
            end
            default: begin
              steps = neg_r ? -$signed({1'b0, quo_step}) : $signed({1'b0, quo_step});
              accum_nxt = neg_r ? -$signed({4'b0, rem_step}) : $signed({4'b0, rem_step});
              if (quo_step != '0) begin
                if (!mode_r[2]) steps = -steps;
                res_nxt[cnt_r[1:0]] = '{KIND_WHEEL, 13'sd0, 13'sd0, steps[15:0], 1'b0};
                cnt_nxt = cnt_r + 3'd1;
                state_nxt = ST_OUT;
              end else if (cnt_r != 3'd0) begin
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_IDLE;
              end
            end
          endcase
        end
      end
      ST_OUT: begin
        if (out_tready) begin
          if (out_tlast) begin
            oidx_nxt = '0;
            cnt_nxt = '0;
            state_nxt = ST_IDLE;
          end else begin
            oidx_nxt = oidx_r + 2'd1;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    if (cfg_valid) begin
      case (cfg_index)
        REG_MODE:   mode_nxt   = cfg_data[2:0];
        REG_THRESH: thr_nxt    = cfg_data[5:0];
        REG_WMAX:   wmax_nxt   = cfg_data[11:0];
        REG_HMAX:   hmax_nxt   = cfg_data[11:0];
        REG_MARGIN: margin_nxt = cfg_data[10:0];
        REG_STEP:   step_nxt   = cfg_data;
        REG_TAPTO:  tapto_nxt  = cfg_data;
        REG_DTW:    dtw_nxt    = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;  sel_r <= SEL_X;
      mode_r <= MODE_RST;  thr_r <= THRESH_RST;  wmax_r <= WMAX_RST;
      hmax_r <= HMAX_RST;  margin_r <= MARGIN_RST;  step_r <= STEP_RST;
      tapto_r <= TAPTO_RST;  dtw_r <= DTW_RST;
      touching_r <= 1'b0;  moved_r <= 1'b0;  scroll_r <= 1'b0;
      drag_r <= 1'b0;  pend_r <= 1'b0;  ringpos_r <= '0;  accum_r <= '0;
      prevx_r <= '0;  prevy_r <= '0;  tstart_r <= '0;  taptime_r <= '0;
      cnt_r <= '0;  oidx_r <= '0;  iter_r <= '0;
    end else begin
      state_r <= state_nxt;  sel_r <= sel_nxt;
      mode_r <= mode_nxt;  thr_r <= thr_nxt;  wmax_r <= wmax_nxt;
      hmax_r <= hmax_nxt;  margin_r <= margin_nxt;  step_r <= step_nxt;
      tapto_r <= tapto_nxt;  dtw_r <= dtw_nxt;
      touching_r <= touching_nxt;  moved_r <= moved_nxt;  scroll_r <= scroll_nxt;
      drag_r <= drag_nxt;  pend_r <= pend_nxt;  ringpos_r <= ringpos_nxt;
      accum_r <= accum_nxt;  prevx_r <= prevx_nxt;  prevy_r <= prevy_nxt;
      tstart_r <= tstart_nxt;  taptime_r <= taptime_nxt;
      cnt_r <= cnt_nxt;  oidx_r <= oidx_nxt;  iter_r <= iter_nxt;
    end
    op_r <= op_nxt;  x_r <= x_nxt;  y_r <= y_nxt;  z_r <= z_nxt;  now_r <= now_nxt;
    quo_r <= quo_nxt;  rem_r <= rem_nxt;  dsr_r <= dsr_nxt;  neg_r <= neg_nxt;
    dy_r <= dy_nxt;  mx_r <= mx_nxt;
    res_r <= res_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/tge_checker.sv =====
// ----------------------------------------------------------------------------
// tge_checker
// Port-level checks of the touchpad gesture engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "touchpad_gesture_engine_defines.svh"
module tge_checker (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tvalid,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [tge_pkg::OUT_DATA_W-1:0]     out_tdata,
  input wire logic [1:0]                         out_tuser,
  input wire logic                               out_tlast
);
  import tge_pkg::*;

  // one request in flight: never take input while results are queued
  `TGE_ASSERT(a_one_side, !(in_tready && out_tvalid), "input taken while results pending")
  `TGE_ASSERT(a_out_hold, (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast)), "stalled result changed")
  `TGE_ASSERT_RST(a_rst_idle, !rst_n |=> (in_tready && !out_tvalid), "not idle after reset")
  `TGE_ASSERT(a_btn_clean, (out_tvalid && out_tuser == KIND_BUTTON) |-> (out_tdata[41:0] == 42'd0), "button result carries motion")

endmodule

bind touchpad_gesture_engine tge_checker u_tge_checker (.*);
`default_nettype wire

// ===== verif/tb_touchpad_gesture_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_touchpad_gesture_engine
// Self-checking bench for the touchpad gesture engine. A directed table
// covers taps, drag toggles, deferred clicks, truncating pointer moves, edge
// scrolling and register extremes. Random gesture streams follow under
// several register settings, with random idling on both stream sides and a
// long output stall. Every result is checked against a local gesture model or a typed table row.
// ----------------------------------------------------------------------------
module tb_touchpad_gesture_engine;
  import tge_pkg::*;

  typedef enum logic { R_ITEM, R_CFG } row_kind_t;
  // how the expected results of a table row are given
  typedef enum logic [2:0] {
    T_PRED, T_NONE, T_CLICK, T_PRESS, T_RELEASE, T_MOVE
  } typed_t;

  typedef struct packed {
    row_kind_t          rk;
    logic [3:0]         idx;
    logic [15:0]        val;
    logic               op;
    logic [11:0]        x;
    logic [11:0]        y;
    logic [5:0]         z;
    logic [31:0]        t;
    typed_t             ty;
    logic signed [12:0] mx;
    logic signed [12:0] my;
  } row_t;

  typedef struct {
    logic [1:0]         kind;
    logic signed [12:0] mx;
    logic signed [12:0] my;
    logic signed [15:0] wh;
    logic               btn;
    logic               last;
  } gesture_t;

  logic        clk;
  logic        rst_n;
  logic [63:0] in_tdata;
  logic        in_tuser;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [3:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        cfg_valid;
  logic        cfg_ready;

  touchpad_gesture_engine dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // runaway guard, far above the slowest legal run
  initial begin
    #5_000_000;
    $display("touchpad_gesture_engine regression: fail");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Gesture model: register copy and finger/tap state
  // --------------------------------------------------------------------------
  bit [2:0]  m_mode;
  bit [5:0]  m_thr;
  bit [11:0] m_wmax, m_hmax;
  bit [10:0] m_margin;
  bit [15:0] m_step, m_tapto, m_dtw;

  bit        touching, moved, scrl, drag_on, tap_pend;
  int        ring_p, ring_acc, px, py;
  bit [31:0] t_start, t_tap;

  gesture_t  gest_q[$];       // results still owed by the engine
  gesture_t  new_res[4];
  int        n_new;

  int errors, n_items, n_results, n_move, n_wheel, n_button;
  bit quiet;                  // no idling on either side
  bit hold_long;              // receiver holds off for a long stretch

  function automatic void add_res(logic [1:0] k, int mx, int my, int wh, bit btn);
    if (n_new < 4) begin
      new_res[n_new].kind = k;
      new_res[n_new].mx   = 13'(mx);
      new_res[n_new].my   = 13'(my);
      new_res[n_new].wh   = 16'(wh);
      new_res[n_new].btn  = btn;
      new_res[n_new].last = 1'b0;
      n_new++;
    end
  endfunction

  function automatic bit edge_band(int x, int y);
    int m;
    m = m_margin;
    return x <= m || x >= int'(m_wmax) - m || y <= m || y >= int'(m_hmax) - m;
  endfunction

  function automatic int ring_at(int x, int y);
    int xm, ym, m;
    xm = m_wmax;
    ym = m_hmax;
    m  = m_margin;
    if (y <= m) return x;
    if (x >= xm - m) return xm + y;
    if (y >= ym - m) return xm + ym + (xm - x);
    return 2 * xm + ym + (ym - y);
  endfunction

  function automatic int ring_diff(int from, int to);
    int half, d;
    half = int'(m_wmax) + int'(m_hmax);
    d = to - from;
    if (d > half) d -= 2 * half;
    else if (d < -half) d += 2 * half;
    return d;
  endfunction

  function automatic void finger_up(bit [31:0] now);
    bit [31:0] held, gap;
    held = now - t_start;
    gap  = now - t_tap;
    if (!m_mode[0] || moved || held > {16'd0, m_tapto}) return;
    if (m_mode[1] && tap_pend && gap <= {16'd0, m_dtw}) begin
      // second tap toggles the held button
      add_res(KIND_BUTTON, 0, 0, 0, !drag_on);
      drag_on  = !drag_on;
      tap_pend = 1'b0;
      return;
    end
    if (m_mode[1]) begin
      t_tap    = now;
      tap_pend = 1'b1;
    end else begin
      if (!drag_on) begin
        add_res(KIND_BUTTON, 0, 0, 0, 1'b1);
        add_res(KIND_BUTTON, 0, 0, 0, 1'b0);
      end
      tap_pend = 1'b0;
    end
  endfunction

  // advances the model by one request, leaves its results in new_res
  function automatic void model_step(bit op, int x, int y, int z, bit [31:0] now);
    bit [31:0] age;
    int dx, dy, ax, ay, pos, stp, steps;
    n_new = 0;
    age = now - t_tap;
    if (tap_pend && age >= {16'd0, m_dtw}) begin
      // deferred single click
      if (!drag_on) begin
        add_res(KIND_BUTTON, 0, 0, 0, 1'b1);
        add_res(KIND_BUTTON, 0, 0, 0, 1'b0);
      end
      tap_pend = 1'b0;
    end
    if (op != OP_SAMPLE) return;
    if (z < int'(m_thr)) begin
      if (touching) finger_up(now);
      touching = 1'b0;
      scrl     = 1'b0;
      ring_acc = 0;
    end else if (!touching) begin
      touching = 1'b1;
      moved    = 1'b0;
      scrl     = edge_band(x, y);
      ring_p   = ring_at(x, y);
      px       = x;
      py       = y;
      t_start  = now;
    end else begin
      dx = x - px;
      dy = y - py;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ax > MOVE_THR_DEF || ay > MOVE_THR_DEF) moved = 1'b1;
      if (!scrl && edge_band(x, y)) begin
        scrl   = 1'b1;
        ring_p = ring_at(x, y);
      end else if (scrl) begin
        pos = ring_at(x, y);
        stp = m_step == 0 ? 1 : int'(m_step);
        ring_acc += ring_diff(ring_p, pos);
        ring_p = pos;
        steps = ring_acc / stp;
        if (steps != 0) begin
          ring_acc -= steps * stp;
          if (!m_mode[2]) steps = -steps;
          add_res(KIND_WHEEL, 0, 0, steps, 1'b0);
        end
      end else begin
        add_res(KIND_MOVE, dx / PTR_DIV_DEF, dy / PTR_DIV_DEF, 0, 1'b0);
      end
      px = x;
      py = y;
    end
  endfunction

  function automatic void model_reg(logic [3:0] idx, logic [15:0] val);
    case (idx)
      REG_MODE:   m_mode   = val[2:0];
      REG_THRESH: m_thr    = val[5:0];
      REG_WMAX:   m_wmax   = val[11:0];
      REG_HMAX:   m_hmax   = val[11:0];
      REG_MARGIN: m_margin = val[10:0];
      REG_STEP:   m_step   = val;
      REG_TAPTO:  m_tapto  = val;
      REG_DTW:    m_dtw    = val;
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Request side
  // --------------------------------------------------------------------------
  task automatic send_req(bit op, int x, int y, int z, bit [31:0] t,
                          typed_t ty, int tmx, int tmy);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {2'b00, t, 6'(z), 12'(y), 12'(x)};
    in_tuser  <= op;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!(in_tvalid && in_tready));
    n_items++;
    model_step(op, x, y, z, t);
    // typed rows replace what the model says; the model state still advances
    if (ty != T_PRED) begin
      n_new = 0;
      case (ty)
        T_CLICK: begin
          add_res(KIND_BUTTON, 0, 0, 0, 1'b1);
          add_res(KIND_BUTTON, 0, 0, 0, 1'b0);
        end
        T_PRESS:   add_res(KIND_BUTTON, 0, 0, 0, 1'b1);
        T_RELEASE: add_res(KIND_BUTTON, 0, 0, 0, 1'b0);
        T_MOVE:    add_res(KIND_MOVE, tmx, tmy, 0, 1'b0);
        default: ;
      endcase
    end
    for (int k = 0; k < n_new; k++) begin
      new_res[k].last = (k == n_new - 1);
      gest_q.push_back(new_res[k]);
    end
  endtask

  // engine idle: all owed results taken, plus the longest no-result latency
  task automatic drain();
    in_tvalid <= 1'b0;
    while (gest_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] val);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    model_reg(idx, val);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  task automatic report(string what, int exp_v, int got_v);
    errors++;
    $display("%0t mismatch %s: expected %0d, got %0d", $realtime, what, exp_v, got_v);
  endtask

  initial begin
    gesture_t e;
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_long) begin
        // long hold-off: results wait in the four-entry buffer and the input stalls
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_long = 1'b0;
      end else begin
        stall = quiet ? 0 : $urandom_range(0, 17);
        if (stall > 0) begin
          out_tready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
      n_results++;
      case (out_tuser)
        KIND_MOVE:   n_move++;
        KIND_WHEEL:  n_wheel++;
        KIND_BUTTON: n_button++;
        default: ;
      endcase
      if (gest_q.size() == 0) begin
        report("unexpected result, kind", -1, out_tuser);
      end else begin
        e = gest_q.pop_front();
        if (out_tuser !== e.kind) report("kind", e.kind, out_tuser);
        if ($signed(out_tdata[12:0]) !== e.mx) report("move_x", e.mx, $signed(out_tdata[12:0]));
        if ($signed(out_tdata[25:13]) !== e.my) report("move_y", e.my, $signed(out_tdata[25:13]));
        if ($signed(out_tdata[41:26]) !== e.wh)
          report("wheel_steps", e.wh, $signed(out_tdata[41:26]));
        if (out_tdata[42] !== e.btn) report("button_down", e.btn, out_tdata[42]);
        if (out_tlast !== e.last) report("tlast", e.last, out_tlast);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed table
  // --------------------------------------------------------------------------
  localparam int DIR_N = 33;
  localparam row_t DIR_TAB [DIR_N] = '{
    // tap to click on
    '{R_CFG,  REG_MODE, 16'd1, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    // tick right after reset: nothing
    '{R_ITEM, 4'd0, 16'd0, OP_TICK, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1000, 12'd1000, 6'd63, 32'd10, T_NONE, 13'sd0, 13'sd0},
    // short lift: click at once
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1000, 12'd1000, 6'd0, 32'd50, T_CLICK, 13'sd0, 13'sd0},
    // pressure exactly at threshold
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1000, 12'd1000, 6'd8, 32'd100, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1400, 12'd600, 6'd63, 32'd110, T_MOVE, 13'sd100, -13'sd100},
    // +3 and -3 both truncate to zero
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1403, 12'd603, 6'd63, 32'd120, T_MOVE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd1400, 12'd600, 6'd63, 32'd130, T_MOVE, 13'sd0, 13'sd0},
    // x beyond the pad: enters the edge band, then scrolls
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd4095, 12'd1500, 6'd63, 32'd140, T_PRED, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd4095, 12'd2000, 6'd63, 32'd150, T_PRED, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd4095, 12'd2000, 6'd0, 32'd160, T_NONE, 13'sd0, 13'sd0},
    // double tap drag
    '{R_CFG,  REG_MODE, 16'd3, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1000, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1010, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1100, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1110, T_PRESS, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1200, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1210, T_NONE, 13'sd0, 13'sd0},
    // drag mode off while the button is held: tap gives nothing
    '{R_CFG,  REG_MODE, 16'd1, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1300, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1310, T_NONE, 13'sd0, 13'sd0},
    '{R_CFG,  REG_MODE, 16'd3, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1400, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1410, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1420, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1430, T_RELEASE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd63, 32'd1500, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd500, 12'd500, 6'd0, 32'd1510, T_NONE, 13'sd0, 13'sd0},
    // window elapsed exactly: deferred click on a bare tick
    '{R_ITEM, 4'd0, 16'd0, OP_TICK, 12'd0, 12'd0, 6'd0, 32'd1860, T_CLICK, 13'sd0, 13'sd0},
    // zero threshold, edge band wider than the pad
    '{R_CFG,  REG_THRESH, 16'd0, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_CFG,  REG_MARGIN, 16'd2047, OP_SAMPLE, 12'd0, 12'd0, 6'd0, 32'd0, T_NONE, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd50, 12'd0, 6'd0, 32'hFFFF_FFF0, T_PRED, 13'sd0, 13'sd0},
    '{R_ITEM, 4'd0, 16'd0, OP_SAMPLE, 12'd4095, 12'd4095, 6'd0, 32'd5, T_PRED, 13'sd0, 13'sd0}
  };

  // --------------------------------------------------------------------------
  // Random gestures
  // --------------------------------------------------------------------------
  bit [31:0] now_ms;

  function automatic int clamp12(int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  function automatic int down_z();
    return $urandom_range(int'(m_thr), 63);
  endfunction

  function automatic int up_z();
    return m_thr == 0 ? 0 : $urandom_range(0, int'(m_thr) - 1);
  endfunction

  task automatic step_ms(int lo, int hi);
    now_ms += $urandom_range(lo, hi);
  endtask

  task automatic one_gesture();
    int g, x, y, n, side, along, depth;
    g = $urandom_range(0, 11);
    x = $urandom_range(0, 4095);
    y = $urandom_range(0, 4095);
    if (g <= 2) begin
      // tap, possibly with a wobble in place
      step_ms(1, 60);
      send_req(OP_SAMPLE, x, y, down_z(), now_ms, T_PRED, 0, 0);
      if ($urandom_range(0, 1)) begin
        step_ms(1, 40);
        send_req(OP_SAMPLE, clamp12(x + $urandom_range(0, 20) - 10), y, down_z(),
                 now_ms, T_PRED, 0, 0);
      end
      step_ms(1, int'(m_tapto) + 40);
      send_req(OP_SAMPLE, x, y, up_z(), now_ms, T_PRED, 0, 0);
    end else if (g <= 4) begin
      // pointer glide
      step_ms(1, 30);
      send_req(OP_SAMPLE, x, y, down_z(), now_ms, T_PRED, 0, 0);
      n = $urandom_range(2, 6);
      repeat (n) begin
        x = clamp12(x + $urandom_range(0, 240) - 120);
        y = clamp12(y + $urandom_range(0, 240) - 120);
        step_ms(1, 20);
        send_req(OP_SAMPLE, x, y, down_z(), now_ms, T_PRED, 0, 0);
      end
      step_ms(1, 30);
      send_req(OP_SAMPLE, x, y, up_z(), now_ms, T_PRED, 0, 0);
    end else if (g <= 7) begin
      // circular scroll along the edge band
      side  = $urandom_range(0, 3);
      along = $urandom_range(0, 4095);
      n = $urandom_range(3, 8);
      for (int k = 0; k <= n; k++) begin
        depth = $urandom_range(0, int'(m_margin));
        case (side)
          0: begin x = along; y = depth; end
          1: begin x = int'(m_wmax) - depth; y = along; end
          2: begin x = along; y = int'(m_hmax) - depth; end
          default: begin x = depth; y = along; end
        endcase
        step_ms(1, 20);
        send_req(OP_SAMPLE, clamp12(x), clamp12(y), down_z(), now_ms, T_PRED, 0, 0);
        along = clamp12(along + $urandom_range(0, 600) - 300);
        if ($urandom_range(0, 4) == 0) side = (side + 1) % 4;
      end
      step_ms(1, 30);
      send_req(OP_SAMPLE, x, y, up_z(), now_ms, T_PRED, 0, 0);
    end else if (g == 8) begin
      step_ms(0, 700);
      send_req(OP_TICK, x, y, $urandom_range(0, 63), now_ms, T_PRED, 0, 0);
    end else if (g <= 10) begin
      // noise: any field, any time
      send_req($urandom_range(0, 1), x, y, $urandom_range(0, 63), $urandom,
               T_PRED, 0, 0);
    end else begin
      // broken: touch without a lift, or a lift on its own
      step_ms(1, 30);
      send_req(OP_SAMPLE, x, y, $urandom_range(0, 1) ? down_z() : up_z(), now_ms,
               T_PRED, 0, 0);
    end
  endtask

  task automatic set_all(int ph);
    logic [15:0] v [8];
    if (ph == 0) begin
      v = '{16'd7, 16'd63, 16'd4095, 16'd4095, 16'd2047, 16'hFFFF, 16'hFFFF, 16'hFFFF};
    end else if (ph == 1) begin
      v = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
    end else begin
      v[0] = 16'($urandom_range(0, 7));
      v[1] = 16'($urandom_range(1, 24));
      v[2] = 16'($urandom_range(800, 4095));
      v[3] = 16'($urandom_range(800, 4095));
      v[4] = 16'($urandom_range(0, 400));
      v[5] = 16'($urandom_range(0, 400));
      v[6] = 16'($urandom_range(20, 300));
      v[7] = 16'($urandom_range(20, 500));
    end
    for (int i = 0; i < 8; i++) write_reg(4'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int start_cnt;
    rst_n     = 1'b0;
    in_tdata  = '0;
    in_tuser  = OP_SAMPLE;
    in_tvalid = 1'b0;
    cfg_index = REG_MODE;
    cfg_data  = '0;
    cfg_valid = 1'b0;
    quiet     = 1'b0;
    hold_long = 1'b0;
    errors = 0; n_items = 0; n_results = 0; n_move = 0; n_wheel = 0; n_button = 0;
    m_mode = MODE_RST; m_thr = THRESH_RST; m_wmax = WMAX_RST; m_hmax = HMAX_RST;
    m_margin = MARGIN_RST; m_step = STEP_RST; m_tapto = TAPTO_RST; m_dtw = DTW_RST;
    touching = 0; moved = 0; scrl = 0; drag_on = 0; tap_pend = 0;
    ring_p = 0; ring_acc = 0; px = 0; py = 0; t_start = 0; t_tap = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_N; i++) begin
      if (DIR_TAB[i].rk == R_CFG) begin
        if (i == 0 || DIR_TAB[i-1].rk != R_CFG) drain();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].val);
        if (i == DIR_N - 1 || DIR_TAB[i+1].rk != R_CFG) cfg_valid <= 1'b0;
      end else begin
        send_req(DIR_TAB[i].op, DIR_TAB[i].x, DIR_TAB[i].y, DIR_TAB[i].z,
                 DIR_TAB[i].t, DIR_TAB[i].ty, DIR_TAB[i].mx, DIR_TAB[i].my);
      end
    end

    // random phases: max extremes, min extremes, then ordinary settings
    now_ms = 32'hFFFF_FC00;   // crosses the 32-bit wrap early on
    for (int ph = 0; ph < 7; ph++) begin
      drain();
      set_all(ph);
      quiet = (ph % 3 == 2);
      if (ph == 3) hold_long = 1'b1;
      start_cnt = n_items;
      while (n_items - start_cnt < 40) one_gesture();
    end

    drain();
    quiet = 1'b0;
    $display("covered %0d requests under 10 register settings: %0d results", n_items, n_results);
    $display("  (%0d pointer moves, %0d wheel, %0d button), %0d mismatches",
             n_move, n_wheel, n_button, errors);
    if (errors == 0) begin
      $display("touchpad_gesture_engine regression: pass");
    end else begin
      $display("touchpad_gesture_engine regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tge_pkg.sv
rtl/touchpad_gesture_engine.sv
rtl/tge_checker.sv
verif/tb_touchpad_gesture_engine.sv
